// ===== rtl/ds2_pkg.sv =====
package ds2_pkg;

  // Widths of the configuration registers and of the stream fields.
  localparam int CFG_W     = 11;
  localparam int PIXEL_W   = 8;
  localparam int SUM_W     = PIXEL_W + 1;
  localparam int TOTAL_W   = PIXEL_W + 2;
  localparam int CFG_IDX_W = 1;

  // Default geometry.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(64);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(2);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Line store operation issued by the counter logic for one accepted beat.
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [CFG_W-1:0] pair_idx;
    logic [SUM_W-1:0] pair_sum;
    logic             frame_end;
  } line_op_t;

endpackage

// ===== rtl/downscale_2x2_box_average.sv =====
// 2x2 box-average downscaler for 8-bit grayscale frames in raster order. It takes one pixel
// beat per clock without pause while the sink keeps up, and gives one output beat for each
// 2x2 block, the four pixels summed and divided by four with truncation; tlast marks the
// last block of the frame. An odd last column or row is dropped. Horizontal pair sums of
// each even row are kept in a line store of MaxWidth/2 entries with one write and one
// registered read port, and are read back on the following odd row. A result passes
// through the read stage and then the output register. The input only pauses when
// the read stage and the output register both hold a result and the sink is not ready.
// The line store needs no clearing after reset. Writing either register restarts the frame
// and is only allowed while no beat is in flight.
module downscale_2x2_box_average #(
  parameter int MaxWidth = ds2_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [ds2_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ds2_pkg::CFG_W-1:0]     cfg_data_i,
  // Pixel input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  // Averaged output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] average
  output logic                          m_axis_tlast   // frame_end
);
  import ds2_pkg::*;

  localparam int LineDepth = MaxWidth / 2;
  localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  line_op_t         op;
  logic             in_fire;
  logic             s1_adv;
  logic [AddrW-1:0] line_addr;
  logic [SUM_W-1:0] line_rdata;
  logic [TOTAL_W-1:0] total;

  logic               s1_valid_q, s1_valid_d;
  logic [SUM_W-1:0]   s1_sum_q, s1_sum_d;
  logic               s1_end_q, s1_end_d;
  logic               out_valid_q, out_valid_d;
  logic [PIXEL_W-1:0] out_avg_q, out_avg_d;
  logic               out_end_q, out_end_d;

  // Handshake: the read stage moves on when the output register is free or being emptied.
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ds2_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (in_fire),
    .pixel_i    (s_axis_tdata),
    .op_o       (op)
  );

  assign line_addr = AddrW'(op.pair_idx);

  ds2_ram #(
    .Width (SUM_W),
    .Depth (LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (op.wr_en),
    .waddr_i (line_addr),
    .wdata_i (op.pair_sum),
    .re_i    (op.rd_en),
    .raddr_i (line_addr),
    .rdata_o (line_rdata)
  );

  // Sum of the stored pair and the new pair; the read data is held until the next read.
  assign total = {1'b0, s1_sum_q} + {1'b0, line_rdata};

  // Read stage: waits for the line store data of an odd-row pair.
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_sum_d   = s1_sum_q;
    s1_end_d   = s1_end_q;
    if (op.rd_en) begin
      s1_valid_d = 1'b1;
      s1_sum_d   = op.pair_sum;
      s1_end_d   = op.frame_end;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Output register: the averaged block waits here until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_avg_d   = out_avg_q;
    out_end_d   = out_end_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
      out_avg_d   = total[TOTAL_W-1:2];
      out_end_d   = s1_end_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sum_q  <= s1_sum_d;
    s1_end_q  <= s1_end_d;
    out_avg_q <= out_avg_d;
    out_end_q <= out_end_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_avg_q;
  assign m_axis_tlast  = out_end_q;

  // A read stage that cannot move on keeps its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("read stage lost a beat while stalled");

endmodule

// ===== rtl/ds2_ram.sv =====
module ds2_ram #(
  parameter int Width = 9,
  parameter int Depth = 512
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port; the read port registers its data and holds it between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ds2_ctrl.sv =====
module ds2_ctrl #(
  parameter int MaxWidth = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ds2_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ds2_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               fire_i,
  input  logic [ds2_pkg::PIXEL_W-1:0]        pixel_i,
  output ds2_pkg::line_op_t                  op_o
);
  import ds2_pkg::*;

  logic [CFG_W-1:0]   width_q, width_d;
  logic [CFG_W-1:0]   height_q, height_d;
  logic [CFG_W-1:0]   col_q, col_d;
  logic [CFG_W-1:0]   row_q, row_d;
  logic [PIXEL_W-1:0] held_q, held_d;
  logic [CFG_W-1:0]   w_eff;
  logic [CFG_W-1:0]   h_eff;
  logic [CFG_W:0]     col_p1;
  logic [CFG_W:0]     col_p2;
  logic [CFG_W:0]     row_p1;
  logic [CFG_W:0]     row_p2;
  logic               last_col;
  logic               last_row;

  // Effective geometry: width clamped to at least two pixels and to the line store, height to at least two rows.
  always_comb begin
    if (width_q < MIN_SIZE) begin
      w_eff = MIN_SIZE;
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = CFG_W'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < MIN_SIZE) ? MIN_SIZE : height_q;
  end

  assign col_p1   = {1'b0, col_q} + (CFG_W+1)'(1);
  assign col_p2   = {1'b0, col_q} + (CFG_W+1)'(2);
  assign row_p1   = {1'b0, row_q} + (CFG_W+1)'(1);
  assign row_p2   = {1'b0, row_q} + (CFG_W+1)'(2);
  assign last_col = col_p1 >= {1'b0, w_eff};
  assign last_row = row_p1 >= {1'b0, h_eff};

  // Line store operation for the current beat: even rows write pair sums, odd rows read them.
  always_comb begin
    op_o.wr_en     = fire_i & col_q[0] & ~row_q[0];
    op_o.rd_en     = fire_i & col_q[0] & row_q[0];
    op_o.pair_idx  = {1'b0, col_q[CFG_W-1:1]};
    op_o.pair_sum  = {1'b0, held_q} + {1'b0, pixel_i};
    op_o.frame_end = (col_p2 >= {1'b0, w_eff}) && (row_p2 >= {1'b0, h_eff});
  end

  // Next state of the counters, the held pixel and the registers.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    held_d   = held_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        REG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
      col_d  = '0;
      row_d  = '0;
      held_d = '0;
    end else if (fire_i) begin
      if (!col_q[0]) begin
        held_d = pixel_i;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_p1[CFG_W-1:0];
      end else begin
        col_d = col_p1[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      held_q   <= held_d;
    end
  end

  // The column counter always stays inside the effective row width.
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q < w_eff)
    else $error("column counter beyond the row width");

  // The row counter always stays inside the effective frame height.
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q < h_eff)
    else $error("row counter beyond the frame height");

  // A beat never both writes and reads the line store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(op_o.wr_en && op_o.rd_en))
    else $error("line store written and read by the same beat");

endmodule
